// ===== design/clm_pkg.sv =====
// Package for the cyclic list match block: sizes, payload structs,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package clm_pkg;

    localparam int MAX_VERTS  = 16;
    localparam int HANDLE_W   = 32;
    localparam int ROT_W      = 4;
    localparam int IDX_W      = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CNT_W      = $clog2(MAX_VERTS + 1);

    typedef struct packed {
        logic signed [HANDLE_W-1:0] first_handle;
        logic signed [HANDLE_W-1:0] second_handle;
        logic                       last;
    } t_req;

    typedef struct packed {
        logic             matched;
        logic             reversed;
        logic [ROT_W-1:0] rotation;
        logic             overflow;
    } t_result;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FWD_RD,
        S_FWD_CMP,
        S_REV_RD,
        S_REV_CMP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // store the current request
        logic srch_init;  // start the search at entry 0
        logic srch_next;  // step the search
        logic fwd_init;   // latch offset, start forward compare
        logic fwd_next;   // step forward compare
        logic rev_init;   // start reverse compare
        logic rev_next;   // step reverse compare
        logic emit;       // publish a result
        logic hit;
        logic rev;
        logic pair;       // rotation comes from rev, not from the offset
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic too_long;
        logic n_one;
        logic n_two;
        logic pair_fwd;
        logic pair_rev;
        logic eq_b_a0;
        logic eq_ab;
        logic i_last;
        logic j_last;
    } t_stat;

endpackage

// ===== design/clm_dp.sv =====
// Datapath of the cyclic list match block: list memories, pair count,
// compare indexes, offset and result register. Uses clm_pkg.
`timescale 1ns / 1ps

module clm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  clm_pkg::t_req    i_req,
    input  clm_pkg::t_cmd    i_cmd,
    output clm_pkg::t_stat   o_stat,
    output logic             o_valid,
    output clm_pkg::t_result o_result
);
    import clm_pkg::*;

    logic [HANDLE_W-1:0] r_mem_a [MAX_VERTS];
    logic [HANDLE_W-1:0] r_mem_b [MAX_VERTS];
    logic [HANDLE_W-1:0] r_ra, r_rb;
    logic [HANDLE_W-1:0] r_a0, r_a1, r_b0, r_b1;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_too_long;
    logic [IDX_W-1:0]    r_i, r_j, r_off;
    logic                r_out_valid;
    t_result             r_out;

    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    j_inc, j_dec, off_dec;
    logic                room;

    assign room     = (r_cnt < CNT_W'(MAX_VERTS));
    assign last_idx = IDX_W'(r_cnt - CNT_W'(1));
    assign j_inc    = (r_j == last_idx) ? '0 : r_j + IDX_W'(1);
    assign j_dec    = (r_j == '0) ? last_idx : r_j - IDX_W'(1);
    // reverse compare starts one place before the found entry
    assign off_dec  = (r_j == '0) ? last_idx : r_j - IDX_W'(1);

    // write incoming pairs while there is room
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_mem_a[r_cnt[IDX_W-1:0]] <= i_req.first_handle;
            r_mem_b[r_cnt[IDX_W-1:0]] <= i_req.second_handle;
        end
    end

    // registered reads, always at the current indexes
    always_ff @(posedge i_clk) begin
        r_ra <= r_mem_a[r_i];
        r_rb <= r_mem_b[r_j];
    end

    // keep the first two pairs for the head compare and the two-entry case
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt == CNT_W'(0)) begin
            r_a0 <= i_req.first_handle;
            r_b0 <= i_req.second_handle;
        end
        if (i_cmd.load && r_cnt == CNT_W'(1)) begin
            r_a1 <= i_req.first_handle;
            r_b1 <= i_req.second_handle;
        end
    end

    // pair count and overflow flag; clear on each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_too_long <= 1'b0;
        end else if (i_cmd.emit) begin
            r_cnt      <= '0;
            r_too_long <= 1'b0;
        end else if (i_cmd.load) begin
            if (room) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_too_long <= 1'b1;
            end
        end
    end

    // advance compare indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i   <= '0;
            r_j   <= '0;
            r_off <= '0;
        end else if (i_cmd.srch_init) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.srch_next) begin
            r_j <= r_j + IDX_W'(1);
        end else if (i_cmd.fwd_init) begin
            r_off <= r_j;
            r_i   <= IDX_W'(1);
            r_j   <= j_inc;
        end else if (i_cmd.fwd_next) begin
            r_i <= r_i + IDX_W'(1);
            r_j <= j_inc;
        end else if (i_cmd.rev_init) begin
            r_i <= IDX_W'(1);
            r_j <= (r_off == '0) ? last_idx : r_off - IDX_W'(1);
        end else if (i_cmd.rev_next) begin
            r_i <= r_i + IDX_W'(1);
            r_j <= j_dec;
        end
    end

    // result register: shown for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.matched  <= i_cmd.hit;
            r_out.reversed <= i_cmd.hit & i_cmd.rev;
            r_out.overflow <= r_too_long;
            if (!i_cmd.hit) begin
                r_out.rotation <= '0;
            end else if (i_cmd.pair) begin
                r_out.rotation <= ROT_W'(i_cmd.rev);
            end else begin
                r_out.rotation <= ROT_W'(r_off);
            end
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.too_long = r_too_long;
        o_stat.n_one    = (r_cnt == CNT_W'(1));
        o_stat.n_two    = (r_cnt == CNT_W'(2));
        o_stat.pair_fwd = (r_a0 == r_b0) && (r_a1 == r_b1);
        o_stat.pair_rev = (r_a0 == r_b1) && (r_a1 == r_b0);
        o_stat.eq_b_a0  = (r_rb == r_a0);
        o_stat.eq_ab    = (r_ra == r_rb);
        o_stat.i_last   = (r_i == last_idx);
        o_stat.j_last   = (r_j == last_idx);
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // off_dec mirrors the reverse start; keep both forms consistent
    a_rev_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rev_init && r_j == r_off |-> ##1 r_j == $past(off_dec))
        else $error("reverse compare start index wrong");

    a_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe longer than one cycle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_VERTS))
        else $error("pair count beyond list depth");

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.matched |-> !r_out.reversed && r_out.rotation == '0)
        else $error("unmatched result carries direction or offset");

    a_overflow_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> !r_out.matched)
        else $error("overflowed lists reported as matched");

endmodule

// ===== design/clm_ctrl.sv =====
// Controller of the cyclic list match block: loads pairs, then sequences
// the head search, forward compare and reverse compare. Uses clm_pkg.
`timescale 1ns / 1ps

module clm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last,
    input  clm_pkg::t_stat i_stat,
    output clm_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import clm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_start && i_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.too_long || i_stat.n_two) n_state = S_LOAD;
                else                                 n_state = S_SRCH_RD;
            end
            S_SRCH_RD: n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (i_stat.eq_b_a0) n_state = i_stat.n_one ? S_LOAD : S_FWD_RD;
                else if (i_stat.j_last) n_state = S_LOAD;
                else n_state = S_SRCH_RD;
            end
            S_FWD_RD: n_state = S_FWD_CMP;
            S_FWD_CMP: begin
                if (!i_stat.eq_ab) n_state = S_REV_RD;
                else if (i_stat.i_last) n_state = S_LOAD;
                else n_state = S_FWD_RD;
            end
            S_REV_RD: n_state = S_REV_CMP;
            S_REV_CMP: begin
                if (!i_stat.eq_ab || i_stat.i_last) n_state = S_LOAD;
                else n_state = S_REV_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = i_start;
            end
            S_DECIDE: begin
                if (i_stat.too_long) begin
                    o_cmd.emit = 1'b1;
                end else if (i_stat.n_two) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.pair = 1'b1;
                    o_cmd.hit  = i_stat.pair_fwd | i_stat.pair_rev;
                    o_cmd.rev  = ~i_stat.pair_fwd;
                end else begin
                    o_cmd.srch_init = 1'b1;
                end
            end
            S_SRCH_RD: ;
            S_SRCH_CMP: begin
                if (i_stat.eq_b_a0) begin
                    if (i_stat.n_one) begin
                        // single entry: equal heads match forward at offset 0
                        o_cmd.emit = 1'b1;
                        o_cmd.hit  = 1'b1;
                        o_cmd.pair = 1'b1;
                    end else begin
                        o_cmd.fwd_init = 1'b1;
                    end
                end else if (i_stat.j_last) begin
                    o_cmd.emit = 1'b1;
                end else begin
                    o_cmd.srch_next = 1'b1;
                end
            end
            S_FWD_RD: ;
            S_FWD_CMP: begin
                if (!i_stat.eq_ab) begin
                    o_cmd.rev_init = 1'b1;
                end else if (i_stat.i_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.hit  = 1'b1;
                end else begin
                    o_cmd.fwd_next = 1'b1;
                end
            end
            S_REV_RD: ;
            S_REV_CMP: begin
                if (!i_stat.eq_ab) begin
                    o_cmd.emit = 1'b1;
                end else if (i_stat.i_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.hit  = 1'b1;
                    o_cmd.rev  = 1'b1;
                end else begin
                    o_cmd.rev_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

    a_emit_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == S_LOAD)
        else $error("controller not idle after a result");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("request stored while busy");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.srch_init, o_cmd.srch_next, o_cmd.fwd_init, o_cmd.fwd_next,
                    o_cmd.rev_init, o_cmd.rev_next, o_cmd.emit}) <= 1)
        else $error("more than one datapath step at once");

endmodule

// ===== design/cyclic_list_match.sv =====
// Top level of the cyclic list match block: controller plus datapath.
// Depends on clm_pkg, clm_ctrl and clm_dp.
`timescale 1ns / 1ps
//
// Usage:
//   Drive one pair of handles per request on i_req with start high; a request
//   is taken at a rising edge where start is high and busy is low. While the
//   list loads, busy stays low, so one pair goes in each cycle.
//   The request with last set ends both lists. busy then rises and, unless
//   the lists overflowed or hold two entries, the block searches the second
//   list for the first list's head, compares forward and, on failure, in reverse.
//   The result appears on o_result with o_valid high for exactly one cycle;
//   the receiver must take it then, it cannot stall the block.
//   Overflowed or two-entry lists get their result straight from the decide
//   state; otherwise each list lives in a memory with one registered read
//   port, so every compared entry passes a read state and then a compare
//   state, over the search and both compares.
//   Pairs past MAX_VERTS are dropped and flagged as overflow.
//   busy falls in the cycle the result is shown, so the next list may start
//   loading while the result is on the ports.
//   Reset (synchronous, active low) empties the lists and returns to loading.
//
module cyclic_list_match (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  clm_pkg::t_req    i_req,
    output logic             o_valid,
    output clm_pkg::t_result o_result
);
    import clm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    clm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_req.last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    clm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
